// ----- hdl/sha256_pkg.sv -----
// sha-256 package: round constants, initial hash, state machine type and helpers
// used by sha256_core and the top level sha256_byte_stream_hasher
package sha256_pkg;

   localparam int unsigned BlockWords = 16;
   localparam int unsigned HashWords = 8;
   localparam int unsigned Rounds = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_COMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } comp_ctl_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] h;
      case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- hdl/sha256_core.sv -----
// sha-256 compression unit: one round per cycle over a 16-word rolling schedule
// depends on sha256_pkg; block words are loaded one per cycle from the block memory
module sha256_core (
   input  logic                       clock,
   input  logic                       reset,
   input  sha256_pkg::comp_ctl_type   ctl_in,     // start pulses in the cycle before word 0
   input  logic [31:0]                word_in,    // block word streamed in order
   input  logic [255:0]               hash_in,    // chain hash a..h, a in top bits
   output logic [255:0]               hash_out,   // updated chain hash
   output logic                       done
);
   import sha256_pkg::*;

   logic [6:0]   round_ff, round_in;
   logic         run_ff, run_in;
   logic [31:0]  w_ff [BlockWords];
   logic [31:0]  v_ff [HashWords];
   logic [31:0]  wt, s0, s1, t1, t2, big0, big1, ch, maj;
   logic         done_ff, done_in;

   // schedule word, round terms and round counter for this round
   always_comb begin
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wt = (round_ff < 7'd16) ? word_in : (w_ff[0] + s0 + w_ff[9] + s1);
      big1 = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + big1 + ch + round_k(round_ff[5:0]) + wt;
      big0 = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = big0 + maj;
      run_in = run_ff;
      round_in = round_ff;
      done_in = 1'b0;
      if (ctl_in.start) begin
         run_in = 1'b1;
         round_in = '0;
      end else if (run_ff) begin
         round_in = round_ff + 7'd1;
         if (round_ff == 7'(Rounds - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         round_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         round_ff <= round_in;
         done_ff <= done_in;
      end
   end

   // round datapath; start loads the working variables, rounds follow one per cycle
   always_ff @(posedge clock) begin
      if (run_ff) begin
         for (int i = 0; i < BlockWords - 1; i++) w_ff[i] <= w_ff[i+1];
         w_ff[BlockWords-1] <= wt;
      end
      if (ctl_in.start) begin
         for (int i = 0; i < HashWords; i++) v_ff[i] <= hash_in[255-32*i -: 32];
      end else if (run_ff) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_comb begin
      for (int i = 0; i < HashWords; i++)
         hash_out[255-32*i -: 32] = hash_in[255-32*i -: 32] + v_ff[i];
   end
   assign done = done_ff;

   assert property (@(posedge clock) disable iff (reset) done |-> !run_ff)
      else $error("done while running");
   assert property (@(posedge clock) disable iff (reset)
      run_ff && !ctl_in.start |-> round_ff < 7'(Rounds))
      else $error("round out of range");
   assert property (@(posedge clock) disable iff (reset) done |=> !done)
      else $error("done held");
   assert property (@(posedge clock) disable iff (reset) run_ff |-> ctl_in.busy)
      else $error("rounds running while the sequencer is not compressing");

endmodule

// ----- hdl/sha256_byte_stream_hasher.sv -----
// sha-256 over a byte stream: top level with block memory and sequencer
// depends on sha256_pkg and sha256_core
//
// channel  dir  handshake        payload
// req      in   tvalid/tready    tdata[7:0] byte, tuser present, tlast message end
// rsp      out  tvalid/tready    tdata[31:0] digest word, tuser[2:0] index, tlast final
//
// bytes are accepted while idle; a byte that fills a block holds the input while
// the core is loaded, runs its rounds and the result is folded into the chain hash
// message end writes the 0x80 word, zeroes each later word of the block and
// compresses it, then zero fills a block with the length when it needs its own block
// then eight digest words are sent, each held while rsp_tready is low
// synchronous reset restores the initial hash and zero length; block memory is not cleared
module sha256_byte_stream_hasher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // byte_present
   input  logic         req_tlast,   // message_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [31:0] digest_word
   output logic [2:0]   rsp_tuser,   // [2:0] word_index
   output logic         rsp_tlast    // final_word
);
   import sha256_pkg::*;

   state_type     state_ff, state_in;
   logic [60:0]   count_ff, count_in;     // message length in bytes
   logic [255:0]  hash_ff;                // chain hash, a in top bits
   logic [255:0]  hash_new;
   logic          last_ff, last_in;       // message end pending after compression
   logic          final_ff, final_in;     // this compression is the last
   logic          pad_more_ff, pad_more_in; // a length-only block follows
   logic [3:0]    pad_ff, pad_in;         // word index during padding
   logic [4:0]    feed_ff, feed_in;       // words sent to the core
   logic [2:0]    out_ff, out_in;
   logic          comp_done;
   comp_ctl_type  ctl;

   // block memory: one write port, one registered read port
   logic [31:0]   mem [BlockWords];
   logic          wr_en;
   logic [3:0]    wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data_ff;

   logic          accept, present;
   logic [5:0]    pos;
   logic [31:0]   cur_word_ff;            // word being built from bytes
   logic [31:0]   cur_word_in;

   assign accept = req_tvalid && req_tready;
   assign present = req_tuser;
   assign pos = count_ff[5:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   sha256_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (ctl),
      .word_in  (rd_data_ff),
      .hash_in  (hash_ff),
      .hash_out (hash_new),
      .done     (comp_done)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      last_in = last_ff;
      final_in = final_ff;
      pad_more_in = pad_more_ff;
      pad_in = pad_ff;
      feed_in = feed_ff;
      out_in = out_ff;
      cur_word_in = cur_word_ff;
      wr_en = 1'b0;
      wr_addr = pos[5:2];
      wr_data = '0;
      rd_addr = feed_ff[3:0];
      ctl.start = 1'b0;
      ctl.busy = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (present) begin
                  // bytes gather in cur_word_ff; memory holds whole or partial words
                  wr_en = 1'b1;
                  case (pos[1:0])
                     2'd0: wr_data = {req_tdata, 24'h0};
                     2'd1: wr_data = {cur_word_ff[31:24], req_tdata, 16'h0};
                     2'd2: wr_data = {cur_word_ff[31:16], req_tdata, 8'h0};
                     default: wr_data = {cur_word_ff[31:8], req_tdata};
                  endcase
                  cur_word_in = wr_data;
                  count_in = count_ff + 61'd1;
                  last_in = req_tlast;
                  if (pos == 6'd63) begin
                     final_in = 1'b0;
                     feed_in = '0;
                     state_in = ST_COMP;
                  end else if (req_tlast) begin
                     state_in = ST_PAD;
                  end
               end else if (req_tlast) begin
                  last_in = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // append 0x80 at current position, zero the rest of its word
            wr_en = 1'b1;
            case (pos[1:0])
               2'd0: wr_data = 32'h80000000;
               2'd1: wr_data = {cur_word_ff[31:24], 24'h800000};
               2'd2: wr_data = {cur_word_ff[31:16], 16'h8000};
               default: wr_data = {cur_word_ff[31:8], 8'h80};
            endcase
            last_in = 1'b0;
            if (pos[5:2] == 4'd15) begin
               // block already full: compress it, the length goes in a block of its own
               pad_more_in = 1'b1;
               final_in = 1'b0;
               feed_in = '0;
               state_in = ST_COMP;
            end else begin
               pad_in = pos[5:2] + 4'd1;
               pad_more_in = (pos[5:2] == 4'd14);
               final_in = (pos[5:2] != 4'd14);
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            // zero fill, then length in words 14 and 15 of the last block
            wr_en = 1'b1;
            wr_addr = pad_ff;
            if (final_ff && pad_ff == 4'd14) wr_data = count_ff[60:29];
            else if (final_ff && pad_ff == 4'd15) wr_data = {count_ff[28:0], 3'b000};
            else wr_data = '0;
            pad_in = pad_ff + 4'd1;
            if (pad_ff == 4'd15) begin
               feed_in = '0;
               state_in = ST_COMP;
            end
         end
         ST_COMP: begin
            // start on entry; read of word k lands as round k runs
            ctl.busy = 1'b1;
            if (feed_ff < 5'd16) feed_in = feed_ff + 5'd1;
            ctl.start = (feed_ff == 5'd0);
            if (comp_done) begin
               if (final_ff) begin
                  out_in = '0;
                  state_in = ST_OUT;
               end else if (pad_more_ff) begin
                  // second padding block: length only
                  pad_more_in = 1'b0;
                  pad_in = '0;
                  final_in = 1'b1;
                  state_in = ST_LEN;
               end else if (last_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  count_in = '0;
                  final_in = 1'b0;
                  pad_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         last_ff <= 1'b0;
         final_ff <= 1'b0;
         pad_more_ff <= 1'b0;
         pad_ff <= '0;
         feed_ff <= '0;
         out_ff <= '0;
         for (int i = 0; i < HashWords; i++) hash_ff[255-32*i -: 32] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff <= last_in;
         final_ff <= final_in;
         pad_more_ff <= pad_more_in;
         pad_ff <= pad_in;
         feed_ff <= feed_in;
         out_ff <= out_in;
         if (comp_done) hash_ff <= hash_new;
         else if (state_ff == ST_OUT && rsp_tready && out_ff == 3'd7)
            for (int i = 0; i < HashWords; i++) hash_ff[255-32*i -: 32] <= init_hash(3'(i));
      end
   end

   always_ff @(posedge clock) begin
      cur_word_ff <= cur_word_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = hash_ff[255-32*out_ff -: 32];
   assign rsp_tuser = out_ff;
   assign rsp_tlast = (out_ff == 3'd7);

   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("input open during digest output");
   assert property (@(posedge clock) disable iff (reset)
      comp_done |-> state_ff == ST_COMP)
      else $error("compression finished outside compress state");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> count_ff == '0)
      else $error("length not cleared after digest");

endmodule
